[sv/oqpe_pkg.sv]
// Shared types and constants for the ordered queue with positional edit.
// Used by oqpe_cell, oqpe_ctrl and ordered_queue_positional_edit.
`default_nettype none
package oqpe_pkg;

	// Index field of the broadcast cell control, wide enough for the largest store.
	localparam int IdxW = 6;

	typedef enum logic [2:0] {
		CMD_PUSH   = 3'd0,
		CMD_POP    = 3'd1,
		CMD_INSERT = 3'd2,
		CMD_DELETE = 3'd3,
		CMD_RUNDEL = 3'd4,
		CMD_DUMP   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_APPEND,
		OP_INSERT,
		OP_DELETE,
		OP_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [IdxW-1:0]   idx;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DUMP,
		S_FIN
	} state_t;

endpackage
`default_nettype wire

[sv/ordered_queue_positional_edit.sv]
// Ordered queue with positional edit: a chain of DEPTH word cells under one sequencer.
// Push, pop, insert, delete and unused codes: S_FIN then loads the output register.
// Run delete: n words removed in S_RUN, one single-word shift per cycle, then S_FIN.
// Dump: one word out per cycle unless out_stall; the chain rotates once per word.
// Next command is taken once the last result is in the output register and out_stall is low.
// Reset clears the word count and control; cell contents stay undefined until written.
`default_nettype none
module ordered_queue_positional_edit #(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         command,
	input  wire logic signed [31:0] value,
	input  wire logic [4:0]         position,
	input  wire logic [4:0]         run_length,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      item_value,
	output logic [4:0]              occupancy,
	output logic [1:0]              status,
	output logic                    last
);

	oqpe_pkg::cell_ctrl_t cell_ctrl;
	logic signed [31:0]   words [DEPTH];

	oqpe_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.position   (position),
		.run_length (run_length),
		.front      (words[0]),
		.cell_ctrl  (cell_ctrl),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.item_value (item_value),
		.occupancy  (occupancy),
		.status     (status),
		.last       (last)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		oqpe_cell #(
			.Index(i)
		) u_cell (
			.clk    (clk),
			.ctrl   (cell_ctrl),
			.value  (value),
			.left   (words[(i == 0) ? 0 : i - 1]),
			.right  (words[(i == DEPTH - 1) ? DEPTH - 1 : i + 1]),
			.front  (words[0]),
			.word_q (words[i])
		);
	end

endmodule
`default_nettype wire

[sv/oqpe_cell.sv]
// One storage cell of the queue chain: holds a word, takes from a neighbour,
// the front or the input word as the broadcast control says. Uses oqpe_pkg.
`default_nettype none
module oqpe_cell #(
	parameter int Index = 0
) (
	input  wire logic                  clk,
	input  wire oqpe_pkg::cell_ctrl_t  ctrl,
	input  wire logic signed [31:0]    value,
	input  wire logic signed [31:0]    left,
	input  wire logic signed [31:0]    right,
	input  wire logic signed [31:0]    front,
	output logic signed [31:0]         word_q
);

	localparam logic [oqpe_pkg::IdxW-1:0] MyIdx = oqpe_pkg::IdxW'(Index);

	logic              load;
	logic signed [31:0] nxt;

	always_comb begin
		load = 1'b0;
		nxt  = value;
		case (ctrl.op)
			oqpe_pkg::OP_APPEND: begin
				load = (ctrl.idx == MyIdx);
			end
			oqpe_pkg::OP_INSERT: begin
				if (ctrl.idx == MyIdx) begin
					load = 1'b1;
				end else if (MyIdx > ctrl.idx) begin
					load = 1'b1;
					nxt  = left;
				end
			end
			oqpe_pkg::OP_DELETE: begin
				load = (MyIdx >= ctrl.idx);
				nxt  = right;
			end
			oqpe_pkg::OP_ROTATE: begin
				// idx marks the back cell, which takes the old front
				if (ctrl.idx == MyIdx) begin
					load = 1'b1;
					nxt  = front;
				end else if (MyIdx < ctrl.idx) begin
					load = 1'b1;
					nxt  = right;
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= nxt;
		end
	end

endmodule
`default_nettype wire

[sv/oqpe_ctrl.sv]
// Command decoder, sequencer and output register of the queue.
// Drives the cell chain through one broadcast control. Uses oqpe_pkg.
`default_nettype none
module oqpe_ctrl #(
	parameter int DEPTH = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [2:0]            command,
	input  wire logic [4:0]            position,
	input  wire logic [4:0]            run_length,
	input  wire logic signed [31:0]    front,
	output oqpe_pkg::cell_ctrl_t       cell_ctrl,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [31:0]         item_value,
	output logic [4:0]                 occupancy,
	output logic [1:0]                 status,
	output logic                       last
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = ((CW > 5) ? CW : 5) + 1;

	oqpe_pkg::state_t  state_q, state_d;
	oqpe_pkg::status_t st_q, st_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [CW-1:0]     rem_q, rem_d;
	logic [oqpe_pkg::IdxW-1:0] idx_q, idx_d;

	logic               out_valid_q;
	logic signed [31:0] item_q;
	logic [4:0]         occ_q;
	oqpe_pkg::status_t  ost_q;
	logic               last_q;

	logic               out_free, acc, load;
	logic signed [31:0] load_item;
	oqpe_pkg::status_t  load_st;
	logic               load_last;

	logic [PW-1:0] cnt_w, pos_w, run_w, avail, nrun;
	logic [oqpe_pkg::IdxW-1:0] pos_idx;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == oqpe_pkg::S_IDLE) && out_free);
	assign acc      = in_valid && !in_stall;

	assign cnt_w   = PW'(cnt_q);
	assign pos_w   = PW'(position);
	assign run_w   = PW'(run_length);
	assign avail   = cnt_w - pos_w + PW'(1);
	assign nrun    = (run_w < avail) ? run_w : avail;
	assign pos_idx = oqpe_pkg::IdxW'(pos_w - PW'(1));

	always_comb begin
		state_d       = state_q;
		st_d          = st_q;
		cnt_d         = cnt_q;
		rem_d         = rem_q;
		idx_d         = idx_q;
		cell_ctrl.op  = oqpe_pkg::OP_HOLD;
		cell_ctrl.idx = '0;
		load          = 1'b0;
		load_item     = front;
		load_st       = oqpe_pkg::ST_OK;
		load_last     = 1'b1;
		case (state_q)
			oqpe_pkg::S_IDLE: begin
				if (acc) begin
					state_d = oqpe_pkg::S_FIN;
					st_d    = oqpe_pkg::ST_OK;
					case (command)
						oqpe_pkg::CMD_PUSH: begin
							if (cnt_w >= PW'(DEPTH)) begin
								st_d = oqpe_pkg::ST_FULL;
							end else begin
								cell_ctrl.op  = oqpe_pkg::OP_APPEND;
								cell_ctrl.idx = oqpe_pkg::IdxW'(cnt_q);
								cnt_d         = cnt_q + CW'(1);
							end
						end
						oqpe_pkg::CMD_POP: begin
							if (cnt_q == '0) begin
								st_d = oqpe_pkg::ST_EMPTY;
							end else begin
								cell_ctrl.op = oqpe_pkg::OP_DELETE;
								cnt_d        = cnt_q - CW'(1);
							end
						end
						oqpe_pkg::CMD_INSERT: begin
							if (cnt_w >= PW'(DEPTH)) begin
								st_d = oqpe_pkg::ST_FULL;
							end else if (pos_w == '0 || pos_w > cnt_w + PW'(1)) begin
								st_d = oqpe_pkg::ST_RANGE;
							end else begin
								cell_ctrl.op  = oqpe_pkg::OP_INSERT;
								cell_ctrl.idx = pos_idx;
								cnt_d         = cnt_q + CW'(1);
							end
						end
						oqpe_pkg::CMD_DELETE: begin
							if (cnt_q == '0) begin
								st_d = oqpe_pkg::ST_EMPTY;
							end else if (pos_w == '0 || pos_w > cnt_w) begin
								st_d = oqpe_pkg::ST_RANGE;
							end else begin
								cell_ctrl.op  = oqpe_pkg::OP_DELETE;
								cell_ctrl.idx = pos_idx;
								cnt_d         = cnt_q - CW'(1);
							end
						end
						oqpe_pkg::CMD_RUNDEL: begin
							if (cnt_q == '0) begin
								st_d = oqpe_pkg::ST_EMPTY;
							end else if (pos_w == '0 || pos_w > cnt_w) begin
								st_d = oqpe_pkg::ST_RANGE;
							end else if (nrun != '0) begin
								// one single-word shift per cycle at the same index
								idx_d   = pos_idx;
								rem_d   = CW'(nrun);
								state_d = oqpe_pkg::S_RUN;
							end
						end
						oqpe_pkg::CMD_DUMP: begin
							if (cnt_q == '0) begin
								st_d = oqpe_pkg::ST_EMPTY;
							end else begin
								rem_d   = cnt_q;
								state_d = oqpe_pkg::S_DUMP;
							end
						end
						default: begin
							st_d = oqpe_pkg::ST_OK;
						end
					endcase
				end
			end
			oqpe_pkg::S_RUN: begin
				cell_ctrl.op  = oqpe_pkg::OP_DELETE;
				cell_ctrl.idx = idx_q;
				cnt_d         = cnt_q - CW'(1);
				rem_d         = rem_q - CW'(1);
				if (rem_q == CW'(1)) begin
					state_d = oqpe_pkg::S_FIN;
				end
			end
			oqpe_pkg::S_DUMP: begin
				// rotate the front to the back; after cnt steps the order is restored
				if (out_free) begin
					load          = 1'b1;
					load_item     = front;
					load_st       = oqpe_pkg::ST_OK;
					load_last     = (rem_q == CW'(1));
					cell_ctrl.op  = oqpe_pkg::OP_ROTATE;
					cell_ctrl.idx = oqpe_pkg::IdxW'(cnt_q - CW'(1));
					rem_d         = rem_q - CW'(1);
					if (rem_q == CW'(1)) begin
						state_d = oqpe_pkg::S_IDLE;
					end
				end
			end
			oqpe_pkg::S_FIN: begin
				if (out_free) begin
					load      = 1'b1;
					load_item = (cnt_q != '0) ? front : 32'sd0;
					load_st   = st_q;
					load_last = 1'b1;
					state_d   = oqpe_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = oqpe_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= oqpe_pkg::S_IDLE;
			cnt_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			rem_q   <= rem_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		st_q  <= st_d;
		idx_q <= idx_d;
		if (load) begin
			item_q <= load_item;
			occ_q  <= 5'(cnt_q);
			ost_q  <= load_st;
			last_q <= load_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign item_value = item_q;
	assign occupancy  = occ_q;
	assign status     = ost_q;
	assign last       = last_q;

endmodule
`default_nettype wire
